[rtl/scg_pkg.sv]
// Package for the size class geometry block: constants, item and pipeline types,
// and small bit-scan helpers. No dependencies.
`timescale 1ns / 1ps

package scg_pkg;

  // Block constants (fixed for the chip).
  localparam int LOG_CHUNK_BYTES    = 21;
  localparam int LOG_PAGE_BYTES     = 12;
  localparam int LOG_LINE_BYTES     = 6;
  localparam int FOLIO_RECORD_BYTES = 64;
  localparam int MAX_PER_FOLIO      = 2048;
  localparam int MID_LIMIT          = 16 * 1024;
  localparam int SMALL_LIMIT        = 256;
  localparam int MAGIC_BASE         = 32;

  localparam logic [47:0] CHUNK_BYTES = 48'(1) << LOG_CHUNK_BYTES;
  localparam logic [47:0] PAGE_BYTES  = 48'(1) << LOG_PAGE_BYTES;

  // Datapath widths.
  localparam int RW      = LOG_CHUNK_BYTES + 1;  // remainder / divisor
  localparam int NSTEP   = MAGIC_BASE;           // quotient bits per chain
  localparam int NLANE   = 4;
  localparam int PER_W   = LOG_PAGE_BYTES + 1;   // objects per folio
  localparam int SMALL_W = $clog2(SMALL_LIMIT) + 1;
  localparam int BYTES_W = NSTEP + 11;

  // Lane assignment.
  localparam int LANE_N    = 0;  // chunk / folio, later usable bytes / folio
  localparam int LANE_PER  = 1;  // folio / object
  localparam int LANE_OMAG = 2;  // object magic
  localparam int LANE_FMAG = 3;  // folio magic

  // Bin categories; the spare code behaves as huge.
  localparam logic [1:0] CAT_SMALL = 2'd0;
  localparam logic [1:0] CAT_LARGE = 2'd1;
  localparam logic [1:0] CAT_HUGE  = 2'd2;
  localparam logic [1:0] CAT_SPARE = 2'd3;

  typedef struct packed {
    logic [47:0] obj_bytes;
    logic [1:0]  category;
  } in_item_t;

  typedef struct packed {
    logic [47:0] folio_bytes;
    logic [15:0] obj_count;
    logic [9:0]  folio_count;
    logic [9:0]  overhead_pages;
    logic [5:0]  obj_shift;
    logic [5:0]  fol_shift;
    logic [33:0] object_multiplier;
    logic [33:0] folio_multiplier;
    logic        limit_exceeded;
  } out_item_t;

  typedef struct packed {
    logic [RW-1:0]    rem;
    logic [RW-1:0]    dvs;
    logic [NSTEP-1:0] num;
    logic [NSTEP-1:0] quo;
  } lane_t;

  typedef lane_t [NLANE-1:0] lane_vec_t;

  typedef struct packed {
    logic [47:0]      folio;
    logic [1:0]       category;
    logic             s_lt_chunk;
    logic             f_big;
    logic             per_div;
    logic [PER_W-1:0] per;
    logic             omag_div;
    logic             fmag_div;
    logic [5:0]       osh;
    logic [5:0]       fsh;
    logic [9:0]       over;
    logic [33:0]      omul;
    logic [33:0]      fmul;
  } side_t;

  typedef struct packed {
    logic      valid;
    lane_vec_t lanes;
    side_t     side;
  } stage_t;

  // Position of the highest set bit; zero for zero.
  function automatic logic [5:0] flog2(input logic [RW-1:0] v);
    logic [5:0] r;
    r = '0;
    for (int i = 0; i < RW; i++) begin
      if (v[i]) r = 6'(i);
    end
    return r;
  endfunction

  // Position of the lowest set bit of a small value.
  function automatic logic [5:0] ctz(input logic [SMALL_W-1:0] v);
    logic [5:0] r;
    r = '0;
    for (int i = SMALL_W - 1; i >= 0; i--) begin
      if (v[i]) r = 6'(i);
    end
    return r;
  endfunction

endpackage

[rtl/size_class_geometry_and_div_magic_top.sv]
// Top level of the size class geometry and division magic block.
// Depends on scg_pkg and scg_chain (which uses scg_cell).
`timescale 1ns / 1ps

// Usage:
//   Present an object size and bin category on item_i and raise start. The
//   item is taken at every rising edge where start is high and busy is low;
//   busy never rises, so a new item can be taken in every cycle.
//   Each item yields one result on result_o, marked by done_o for exactly one
//   cycle once the item has passed both rows and the output register. Results
//   leave in the order the items came in. The receiver cannot hold results off,
//   and the block never needs it to: every stage advances each cycle.
//   The pipeline is two rows of 32 divider cells. The first row works out
//   chunk/folio, folio/object and the two magic quotients at once; the second
//   row divides the usable chunk bytes by the folio size, which needs the
//   overhead page count that falls out of the first row. The input register
//   loads at the accepting edge itself; the output register follows row two.
//   Throughput: one item per cycle.
//   Reset clears all valid flags at once; no item is in flight afterwards and
//   no result strobe appears until a new item is taken.
//   Magic numbers: q = (offset * multiplier) >> shift.

module size_class_geometry_and_div_magic_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  scg_pkg::in_item_t   item_i,
  output logic                done_o,
  output scg_pkg::out_item_t  result_o
);
  import scg_pkg::*;

  // Input register.
  in_item_t  in_q;
  logic      in_vld_q;

  stage_t    a_in, a_out, b_in, b_out;

  out_item_t out_d, out_q;
  logic      done_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_q <= item_i;
    end
  end

  // Prepare: folio size, directly known results and the first row's lanes.
  always_comb begin
    logic [47:0]   s;
    logic          s_le_chunk;
    logic          s_pow2;
    logic [RW-1:0] s_low;
    logic [5:0]    s_lg;
    logic [5:0]    s_k;
    logic [5:0]    tz;
    logic [47:0]   folio;
    logic          f_pow2;
    logic [RW-1:0] f_low;
    logic [5:0]    f_lg;
    logic [5:0]    f_k;
    logic [RW-1:0] one_rw;

    s          = in_q.obj_bytes;
    s_le_chunk = s <= CHUNK_BYTES;
    s_pow2     = (s & (s - 48'd1)) == 48'd0;
    s_low      = s[RW-1:0];
    s_lg       = flog2(s_low);
    s_k        = s_lg + 6'd1;
    tz         = ctz(s[SMALL_W-1:0]);
    one_rw     = RW'(1);

    a_in       = '0;
    a_in.valid = in_vld_q;
    a_in.side.category   = in_q.category;
    a_in.side.s_lt_chunk = s < CHUNK_BYTES;
    a_in.side.per        = PER_W'(1);

    // folio size and objects per folio where no division is needed
    priority if (!s_le_chunk) begin
      folio = s;
    end else if (s_pow2) begin
      folio = (s < PAGE_BYTES) ? PAGE_BYTES : s;
      if (s == 48'd0) begin
        a_in.side.per = '0;
      end else if (s < PAGE_BYTES) begin
        a_in.side.per = PER_W'(1) << (6'(LOG_PAGE_BYTES) - s_lg);
      end
    end else if (s > 48'(MID_LIMIT)) begin
      folio = s;
    end else if (s > 48'(SMALL_LIMIT)) begin
      folio = (s >> LOG_LINE_BYTES) << LOG_PAGE_BYTES;
      a_in.side.per_div = 1'b1;
    end else begin
      folio = (s >> tz) << LOG_PAGE_BYTES;
      a_in.side.per = PER_W'(1) << (6'(LOG_PAGE_BYTES) - tz);
    end

    f_pow2 = (folio & (folio - 48'd1)) == 48'd0;
    f_low  = folio[RW-1:0];
    f_lg   = flog2(f_low);
    f_k    = f_lg + 6'd1;

    a_in.side.folio = folio;
    a_in.side.f_big = folio > CHUNK_BYTES;

    // object magic
    priority if (!s_le_chunk) begin
      a_in.side.osh = 6'd1;
    end else if (s_pow2) begin
      a_in.side.osh = s_lg;
    end else begin
      a_in.side.osh      = 6'(MAGIC_BASE) + s_k;
      a_in.side.omag_div = 1'b1;
    end

    // folio magic
    priority if (folio > CHUNK_BYTES) begin
      a_in.side.fsh = 6'd1;
    end else if (f_pow2) begin
      a_in.side.fsh = f_lg;
    end else begin
      a_in.side.fsh      = 6'(MAGIC_BASE) + f_k;
      a_in.side.fmag_div = 1'b1;
    end

    // chunk / folio
    a_in.lanes[LANE_N].dvs = f_low;
    a_in.lanes[LANE_N].num = NSTEP'(CHUNK_BYTES);
    // folio / object, middle sizes
    a_in.lanes[LANE_PER].dvs = s_low;
    a_in.lanes[LANE_PER].num = folio[NSTEP-1:0];
    // 2^(32+k) / d: start from the remainder after the leading quotient bit
    a_in.lanes[LANE_OMAG].dvs = s_low;
    a_in.lanes[LANE_OMAG].rem = (one_rw << s_k) - s_low;
    a_in.lanes[LANE_FMAG].dvs = f_low;
    a_in.lanes[LANE_FMAG].rem = (one_rw << f_k) - f_low;
  end

  scg_chain u_chain_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (a_in),
    .stage_o (a_out)
  );

  // Between rows: overhead pages, magic multipliers, usable chunk bytes.
  always_comb begin
    logic [NSTEP-1:0]   n;
    logic [BYTES_W-1:0] bytes;
    logic [BYTES_W-1:0] pages;
    logic [47:0]        used;
    logic [47:0]        avail;

    b_in       = '0;
    b_in.valid = a_out.valid;
    b_in.side  = a_out.side;

    n     = a_out.side.f_big ? '0 : a_out.lanes[LANE_N].quo;
    bytes = BYTES_W'(n) * BYTES_W'(FOLIO_RECORD_BYTES);
    pages = (bytes + BYTES_W'(PAGE_BYTES - 48'd1)) >> LOG_PAGE_BYTES;

    if (a_out.side.category == CAT_SMALL) begin
      b_in.side.over = (pages > BYTES_W'(1023)) ? 10'd1023 : pages[9:0];
    end else if (a_out.side.category == CAT_LARGE) begin
      b_in.side.over = 10'd1;
    end else begin
      b_in.side.over = 10'd0;
    end

    if (a_out.side.per_div) begin
      b_in.side.per = a_out.lanes[LANE_PER].quo[PER_W-1:0];
    end

    b_in.side.omul = a_out.side.omag_div
                   ? {2'b01, a_out.lanes[LANE_OMAG].quo}
                     + 34'(a_out.lanes[LANE_OMAG].rem != '0)
                   : 34'd1;
    b_in.side.fmul = a_out.side.fmag_div
                   ? {2'b01, a_out.lanes[LANE_FMAG].quo}
                     + 34'(a_out.lanes[LANE_FMAG].rem != '0)
                   : 34'd1;

    used  = 48'(b_in.side.over) << LOG_PAGE_BYTES;
    avail = (used > CHUNK_BYTES) ? 48'd0 : CHUNK_BYTES - used;

    b_in.lanes[LANE_N].dvs = a_out.side.folio[RW-1:0];
    b_in.lanes[LANE_N].num = avail[NSTEP-1:0];
  end

  scg_chain u_chain_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (b_in),
    .stage_o (b_out)
  );

  // Final assembly of the result item.
  always_comb begin
    logic [NSTEP-1:0] fpc;
    fpc = b_out.lanes[LANE_N].quo;

    out_d.folio_bytes = b_out.side.folio;
    out_d.obj_count   = (32'(b_out.side.per) > 32'(16'hFFFF))
                      ? 16'hFFFF : 16'(b_out.side.per);
    if (b_out.side.s_lt_chunk) begin
      out_d.folio_count = (fpc > NSTEP'(1023)) ? 10'd1023 : fpc[9:0];
    end else begin
      out_d.folio_count = 10'd1;
    end
    out_d.overhead_pages    = b_out.side.over;
    out_d.obj_shift         = b_out.side.osh;
    out_d.fol_shift         = b_out.side.fsh;
    out_d.object_multiplier = b_out.side.omul;
    out_d.folio_multiplier  = b_out.side.fmul;
    out_d.limit_exceeded    = 32'(b_out.side.per) > 32'(MAX_PER_FOLIO);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= b_out.valid;
    end
  end

  // Hold the payload only when a result arrives.
  always_ff @(posedge clk_i) begin
    if (b_out.valid) begin
      out_q <= out_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = out_q;

endmodule

[rtl/scg_cell.sv]
// One divider cell: a restoring step on every lane, registered.
// Depends on scg_pkg.
`timescale 1ns / 1ps

module scg_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  scg_pkg::stage_t stage_i,
  output scg_pkg::stage_t stage_o
);
  import scg_pkg::*;

  lane_vec_t lanes_d, lanes_q;
  side_t     side_q;
  logic      valid_q;

  always_comb begin
    logic [RW:0] r2;
    logic [RW:0] diff;
    logic        ge;
    lanes_d = stage_i.lanes;
    for (int l = 0; l < NLANE; l++) begin
      // shift in the next dividend bit, subtract when it fits
      r2   = {stage_i.lanes[l].rem, stage_i.lanes[l].num[NSTEP-1]};
      diff = r2 - {1'b0, stage_i.lanes[l].dvs};
      ge   = r2 >= {1'b0, stage_i.lanes[l].dvs};
      lanes_d[l].rem = ge ? diff[RW-1:0] : r2[RW-1:0];
      lanes_d[l].num = {stage_i.lanes[l].num[NSTEP-2:0], 1'b0};
      lanes_d[l].quo = {stage_i.lanes[l].quo[NSTEP-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    lanes_q <= lanes_d;
    side_q  <= stage_i.side;
  end

  assign stage_o = '{valid: valid_q, lanes: lanes_q, side: side_q};

endmodule

[rtl/scg_chain.sv]
// Row of divider cells, one quotient bit per cell for every lane.
// Depends on scg_pkg and scg_cell.
`timescale 1ns / 1ps

module scg_chain (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  scg_pkg::stage_t stage_i,
  output scg_pkg::stage_t stage_o
);
  import scg_pkg::*;

  stage_t link [NSTEP+1];

  assign link[0] = stage_i;

  for (genvar c = 0; c < NSTEP; c++) begin : g_cell
    scg_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (link[c]),
      .stage_o (link[c+1])
    );
  end

  assign stage_o = link[NSTEP];

endmodule
